[rtl/core/pas_pkg.sv]
// pas_pkg: shared constants and types for the polyline arc-length sampler
// depends on nothing; imported by pas_ctrl, pas_dp, the top level and the testbench
package pas_pkg;

    localparam int MAX_POINTS = 256;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 24;
    localparam int LEN_W      = 32;
    localparam int POS_W      = 17;
    localparam int SQ_W       = 50;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int FRAC_W     = 16;
    localparam int STEP_W     = 5;

    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1 << FRAC_W);

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [LEN_W-1:0]          cum;
    } mem_entry_t;

    typedef struct packed {
        logic load;
        logic dispatch;
        logic diff;
        logic sq_x;
        logic sq_y;
        logic sum;
        logic sqrt_step;
        logic seg;
        logic tgt;
        logic probe;
        logic cmp;
        logic rd_lo;
        logic rd_hi;
        logic cap_hi;
        logic div_init;
        logic div_step;
        logic lerp_x;
        logic lerp_y;
        logic fin_y;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_query;
        logic empty;
        logic full;
        logic phase_close;
        logic step_last;
        logic search_more;
        logic hit;
        logic out_free;
    } dp_stat_t;

endpackage

[rtl/core/pas_ctrl.sv]
// pas_ctrl: sequencing state machine for append and query transactions
// depends on pas_pkg; drives pas_dp through dp_cmd_t, reads dp_stat_t
module pas_ctrl
    import pas_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [19:0] {
        S_IDLE    = 20'h00001,
        S_DISPATCH = 20'h00002,
        S_DIFF    = 20'h00004,
        S_SQX     = 20'h00008,
        S_SQY     = 20'h00010,
        S_SUM     = 20'h00020,
        S_SQRT    = 20'h00040,
        S_SEG     = 20'h00080,
        S_TGT     = 20'h00100,
        S_SEARCH  = 20'h00200,
        S_CMP     = 20'h00400,
        S_RDLO    = 20'h00800,
        S_RDHI    = 20'h01000,
        S_CAPHI   = 20'h02000,
        S_DIVINIT = 20'h04000,
        S_DIV     = 20'h08000,
        S_LX      = 20'h10000,
        S_LY      = 20'h20000,
        S_PY      = 20'h40000,
        S_DONE    = 20'h80000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                cmd.dispatch = 1'b1;
                if (stat.is_query) begin
                    state_next = stat.empty ? S_DONE : S_TGT;
                end else if (stat.full || stat.empty) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = S_SQX;
            end
            S_SQX: begin
                cmd.sq_x   = 1'b1;
                state_next = S_SQY;
            end
            S_SQY: begin
                cmd.sq_y   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (stat.step_last) begin
                    state_next = S_SEG;
                end
            end
            S_SEG: begin
                cmd.seg    = 1'b1;
                state_next = stat.phase_close ? S_DONE : S_DIFF;
            end
            S_TGT: begin
                cmd.tgt    = 1'b1;
                state_next = S_SEARCH;
            end
            S_SEARCH: begin
                if (stat.search_more) begin
                    cmd.probe  = 1'b1;
                    state_next = S_CMP;
                end else begin
                    state_next = S_RDLO;
                end
            end
            S_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = stat.hit ? S_DONE : S_SEARCH;
            end
            S_RDLO: begin
                cmd.rd_lo  = 1'b1;
                state_next = S_RDHI;
            end
            S_RDHI: begin
                cmd.rd_hi  = 1'b1;
                state_next = S_CAPHI;
            end
            S_CAPHI: begin
                cmd.cap_hi = 1'b1;
                state_next = S_DIVINIT;
            end
            S_DIVINIT: begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.step_last) begin
                    state_next = S_LX;
                end
            end
            S_LX: begin
                cmd.lerp_x = 1'b1;
                state_next = S_LY;
            end
            S_LY: begin
                cmd.lerp_y = 1'b1;
                state_next = S_PY;
            end
            S_PY: begin
                cmd.fin_y  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted a transaction while busy");

endmodule

[rtl/core/pas_dp.sv]
// pas_dp: vertex store, square root, search, divider, interpolation, output register
// depends on pas_pkg; commanded by pas_ctrl
module pas_dp
    import pas_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    input  logic                      cfg_closed_path,
    input  logic                      s_command,
    input  logic                      s_start_new,
    input  logic signed [COORD_W-1:0] s_vertex_x,
    input  logic signed [COORD_W-1:0] s_vertex_y,
    input  logic [POS_W-1:0]          s_position,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_point_x,
    output logic signed [COORD_W-1:0] m_point_y,
    output logic [LEN_W-1:0]          m_total_length,
    output logic [1:0]                m_status,
    input  dp_cmd_t                   cmd,
    output dp_stat_t                  stat
);

    mem_entry_t mem [MAX_POINTS];
    mem_entry_t rd_data_reg;

    logic                      closed_reg;
    logic                      is_query_reg;
    logic [POS_W-1:0]          pos_reg;
    logic signed [COORD_W-1:0] in_x_reg, in_y_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [LEN_W-1:0]          closing_reg, last_cum_reg, cum_new_reg;
    logic signed [COORD_W-1:0] last_x_reg, last_y_reg, first_x_reg, first_y_reg;
    logic                      phase_reg;
    logic signed [COORD_W:0]   dx_reg, dy_reg;
    logic signed [SQ_W-1:0]    mul_reg;
    logic [SQ_W-2:0]           acc_reg;
    logic [SQ_W-1:0]           rad_reg, root_reg, bit_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [LEN_W-1:0]          total_q_reg, dlo_reg, dhi_reg;
    logic [CNT_W-1:0]          lo_reg, hi_reg, mid_reg;
    logic signed [COORD_W-1:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic [SQ_W-1:0]           rem_reg;
    logic [SQ_W-3:0]           dvs_reg;
    logic [POS_W-1:0]          q_reg;
    logic                      fz_reg, fsat_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;
    status_t                   status_reg;
    logic                      m_valid_reg;
    logic signed [COORD_W-1:0] m_px_reg, m_py_reg;
    logic [LEN_W-1:0]          m_total_reg;
    logic [1:0]                m_status_reg;

    logic [LEN_W:0]            tot_sum, cum_sum;
    logic [LEN_W-1:0]          total_c;
    logic [SQ_W-7:0]           root_fin;
    logic [SQ_W:0]             rb;
    logic                      sq_ge;
    logic [CNT_W:0]            mid_sum;
    logic [CNT_W-1:0]          mid_c, lo_idx, hi_idx;
    logic [SQ_W-3:0]           target;
    logic [SQ_W-3:0]           probe_d;
    logic [LEN_W-1:0]          seg_c, rd_dist;
    logic [SQ_W-3:0]           base_c;
    logic [SQ_W-1:0]           num_c;
    logic                      div_ge;
    logic [POS_W-1:0]          f_c;
    logic signed [LEN_W:0]     mul_a, mul_b;
    logic signed [2*LEN_W+1:0] mul_full;
    logic signed [SQ_W-1:0]    rnd_sum;
    logic signed [SQ_W-17:0]   rnd_c;
    logic signed [SQ_W-17:0]   pnt_x, pnt_y;
    logic                      wr_en;
    mem_entry_t                wr_data;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;

    assign tot_sum = {1'b0, last_cum_reg} + {1'b0, closing_reg};
    always_comb begin
        if (count_reg == '0) begin
            total_c = '0;
        end else if (closed_reg) begin
            total_c = tot_sum[LEN_W] ? '1 : tot_sum[LEN_W-1:0];
        end else begin
            total_c = last_cum_reg;
        end
    end

    assign root_fin = root_reg[SQ_W-7:0] + (SQ_W-6)'(rad_reg > root_reg);
    assign cum_sum  = {1'b0, last_cum_reg} + (LEN_W+1)'(root_fin);
    assign rb       = {1'b0, root_reg} + {1'b0, bit_reg};
    assign sq_ge    = {1'b0, rad_reg} >= rb;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_c   = mid_sum[CNT_W:1];
    assign lo_idx  = (lo_reg >= count_reg) ? '0 : lo_reg;
    assign hi_idx  = (hi_reg >= count_reg) ? '0 : hi_reg;
    assign target  = mul_reg[SQ_W-3:0];
    assign probe_d = {rd_data_reg.cum, 16'd0};

    assign seg_c  = (dhi_reg > dlo_reg) ? (dhi_reg - dlo_reg) : '0;
    assign base_c = {dlo_reg, 16'd0};
    assign num_c  = SQ_W'(target - base_c) + SQ_W'(seg_c >> 1);
    assign div_ge = rem_reg >= {2'b00, dvs_reg};

    always_comb begin
        if (fz_reg) begin
            f_c = '0;
        end else if (fsat_reg || (q_reg > POS_ONE)) begin
            f_c = POS_ONE;
        end else begin
            f_c = q_reg;
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.sq_x) begin
            mul_a = (LEN_W+1)'(dx_reg);
            mul_b = (LEN_W+1)'(dx_reg);
        end else if (cmd.sq_y) begin
            mul_a = (LEN_W+1)'(dy_reg);
            mul_b = (LEN_W+1)'(dy_reg);
        end else if (cmd.tgt) begin
            mul_a = $signed({{(LEN_W+1-POS_W){1'b0}}, pos_reg});
            mul_b = $signed({1'b0, total_c});
        end else if (cmd.lerp_x) begin
            mul_a = (LEN_W+1)'(26'(xb_reg) - 26'(xa_reg));
            mul_b = $signed({{(LEN_W+1-POS_W){1'b0}}, f_c});
        end else if (cmd.lerp_y) begin
            mul_a = (LEN_W+1)'(26'(yb_reg) - 26'(ya_reg));
            mul_b = $signed({{(LEN_W+1-POS_W){1'b0}}, f_c});
        end
    end
    assign mul_full = mul_a * mul_b;

    assign rnd_sum = mul_reg + SQ_W'(32768);
    assign rnd_c   = rnd_sum[SQ_W-1:16];
    assign pnt_x   = (SQ_W-16)'(xa_reg) + rnd_c;
    assign pnt_y   = (SQ_W-16)'(ya_reg) + rnd_c;

    assign wr_en = (cmd.dispatch && !is_query_reg && count_reg == '0)
                || (cmd.seg && phase_reg);
    always_comb begin
        wr_data.x   = in_x_reg;
        wr_data.y   = in_y_reg;
        wr_data.cum = (count_reg == '0) ? '0 : cum_new_reg;
    end
    assign rd_en = cmd.probe || cmd.rd_lo || cmd.rd_hi;
    always_comb begin
        if (cmd.probe) begin
            rd_addr = mid_c[ADDR_W-1:0];
        end else if (cmd.rd_lo) begin
            rd_addr = lo_idx[ADDR_W-1:0];
        end else begin
            rd_addr = hi_idx[ADDR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[ADDR_W-1:0]] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_dist = rd_data_reg.cum;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            closed_reg   <= 1'b0;
            count_reg    <= '0;
            closing_reg  <= '0;
            last_cum_reg <= '0;
            phase_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                closed_reg <= cfg_closed_path;
            end
            if (cmd.load && s_command == CMD_APPEND && s_start_new) begin
                count_reg   <= '0;
                closing_reg <= '0;
            end
            if (cmd.dispatch && !is_query_reg) begin
                phase_reg <= 1'b0;
                if (count_reg == '0) begin
                    count_reg    <= CNT_W'(1);
                    closing_reg  <= '0;
                    last_cum_reg <= '0;
                end
            end
            if (cmd.seg) begin
                if (!phase_reg) begin
                    phase_reg <= 1'b1;
                end else begin
                    phase_reg    <= 1'b0;
                    closing_reg  <= LEN_W'(root_fin);
                    last_cum_reg <= cum_new_reg;
                    count_reg    <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            is_query_reg <= s_command;
            in_x_reg     <= s_vertex_x;
            in_y_reg     <= s_vertex_y;
            pos_reg      <= (s_position > POS_ONE) ? POS_ONE : s_position;
        end
        if (cmd.dispatch) begin
            px_reg <= '0;
            py_reg <= '0;
            if (is_query_reg) begin
                if (count_reg == '0) begin
                    status_reg <= ST_EMPTY;
                end else begin
                    status_reg <= ST_OK;
                end
            end else if (count_reg >= CNT_W'(MAX_POINTS)) begin
                status_reg <= ST_FULL;
            end else begin
                status_reg <= ST_OK;
                if (count_reg == '0) begin
                    first_x_reg <= in_x_reg;
                    first_y_reg <= in_y_reg;
                    last_x_reg  <= in_x_reg;
                    last_y_reg  <= in_y_reg;
                end
            end
        end
        if (cmd.diff) begin
            if (!phase_reg) begin
                dx_reg <= (COORD_W+1)'(in_x_reg) - (COORD_W+1)'(last_x_reg);
                dy_reg <= (COORD_W+1)'(in_y_reg) - (COORD_W+1)'(last_y_reg);
            end else begin
                dx_reg <= (COORD_W+1)'(in_x_reg) - (COORD_W+1)'(first_x_reg);
                dy_reg <= (COORD_W+1)'(in_y_reg) - (COORD_W+1)'(first_y_reg);
            end
        end
        if (cmd.sq_x || cmd.sq_y || cmd.tgt || cmd.lerp_x || cmd.lerp_y) begin
            mul_reg <= mul_full[SQ_W-1:0];
        end
        if (cmd.sq_y) begin
            acc_reg <= mul_reg[SQ_W-2:0];
        end
        if (cmd.sum) begin
            rad_reg  <= {1'b0, acc_reg} + mul_reg;
            root_reg <= '0;
            bit_reg  <= SQ_W'(1) << (SQ_W - 2);
            step_reg <= STEP_W'(SQRT_STEPS - 1);
        end
        if (cmd.sqrt_step) begin
            if (sq_ge) begin
                rad_reg  <= rad_reg - rb[SQ_W-1:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg  <= bit_reg >> 2;
            step_reg <= step_reg - STEP_W'(1);
        end
        if (cmd.seg && !phase_reg) begin
            cum_new_reg <= cum_sum[LEN_W] ? '1 : cum_sum[LEN_W-1:0];
        end
        if (cmd.seg && phase_reg) begin
            last_x_reg <= in_x_reg;
            last_y_reg <= in_y_reg;
        end
        if (cmd.tgt) begin
            total_q_reg <= total_c;
            lo_reg      <= '0;
            hi_reg      <= count_reg + CNT_W'(closed_reg) - CNT_W'(1);
        end
        if (cmd.probe) begin
            mid_reg <= mid_c;
        end
        if (cmd.cmp) begin
            if (probe_d > target) begin
                hi_reg <= mid_reg;
            end else if (probe_d < target) begin
                lo_reg <= mid_reg;
            end else begin
                px_reg <= rd_data_reg.x;
                py_reg <= rd_data_reg.y;
            end
        end
        if (cmd.rd_hi) begin
            dlo_reg <= (lo_reg >= count_reg) ? total_q_reg : rd_dist;
            xa_reg  <= rd_data_reg.x;
            ya_reg  <= rd_data_reg.y;
        end
        if (cmd.cap_hi) begin
            dhi_reg <= (hi_reg >= count_reg) ? total_q_reg : rd_dist;
            xb_reg  <= rd_data_reg.x;
            yb_reg  <= rd_data_reg.y;
        end
        if (cmd.div_init) begin
            fz_reg   <= (seg_c == '0) || (target <= base_c);
            fsat_reg <= num_c >= {1'b0, seg_c, 17'd0};
            rem_reg  <= num_c;
            dvs_reg  <= {seg_c, 16'd0};
            q_reg    <= '0;
            step_reg <= STEP_W'(POS_W - 1);
        end
        if (cmd.div_step) begin
            if (div_ge) begin
                rem_reg <= rem_reg - {2'b00, dvs_reg};
            end
            q_reg    <= {q_reg[POS_W-2:0], div_ge};
            dvs_reg  <= dvs_reg >> 1;
            step_reg <= step_reg - STEP_W'(1);
        end
        if (cmd.lerp_y) begin
            px_reg <= pnt_x[COORD_W-1:0];
        end
        if (cmd.fin_y) begin
            py_reg <= pnt_y[COORD_W-1:0];
        end
        if (cmd.out_load) begin
            m_px_reg     <= px_reg;
            m_py_reg     <= py_reg;
            m_total_reg  <= total_c;
            m_status_reg <= status_reg;
        end
    end

    always_comb begin
        stat.is_query    = is_query_reg;
        stat.empty       = (count_reg == '0);
        stat.full        = (count_reg >= CNT_W'(MAX_POINTS));
        stat.phase_close = phase_reg;
        stat.step_last   = (step_reg == '0);
        stat.search_more = (hi_reg - lo_reg) > CNT_W'(1);
        stat.hit         = (probe_d == target);
        stat.out_free    = !m_valid_reg || m_ready;
    end

    assign m_valid        = m_valid_reg;
    assign m_point_x      = m_px_reg;
    assign m_point_y      = m_py_reg;
    assign m_total_length = m_total_reg;
    assign m_status       = m_status_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("vertex count beyond store depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("result register not valid after load");

endmodule

[rtl/core/polyline_arc_length_sampler.sv]
// polyline_arc_length_sampler: top level, one transaction in flight at a time
// append to a non-empty path: two 25-step square roots (segment, closing) before m_valid
// query: up to 8 search probes plus a 17-step divider; a hit ends early
// empty query, full store or first vertex go straight to done; next accept in the cycle after the result loads
// a result held by m_ready low stalls the next transaction in the done state
// synchronous active-low reset clears control state and vertex count; no clearing pass
module polyline_arc_length_sampler
    import pas_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_closed_path,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_command,
    input  logic                      s_start_new,
    input  logic signed [COORD_W-1:0] s_vertex_x,
    input  logic signed [COORD_W-1:0] s_vertex_y,
    input  logic [POS_W-1:0]          s_position,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_point_x,
    output logic signed [COORD_W-1:0] m_point_y,
    output logic [LEN_W-1:0]          m_total_length,
    output logic [1:0]                m_status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    pas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pas_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_closed_path (cfg_closed_path),
        .s_command       (s_command),
        .s_start_new     (s_start_new),
        .s_vertex_x      (s_vertex_x),
        .s_vertex_y      (s_vertex_y),
        .s_position      (s_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_point_x       (m_point_x),
        .m_point_y       (m_point_y),
        .m_total_length  (m_total_length),
        .m_status        (m_status),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

[verif/polyline_arc_length_sampler_tb.sv]
// polyline_arc_length_sampler_tb: self-checking testbench for the polyline sampler
// predicts each result from its own path store and compares every m_ transaction
// depends on pas_pkg and polyline_arc_length_sampler
module polyline_arc_length_sampler_tb;
    import pas_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [LEN_W-1:0]          len;
        logic [1:0]                st;
    } sample_t;

    logic aclk;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_closed_path;
    logic s_valid;
    logic s_ready;
    logic s_command;
    logic s_start_new;
    logic signed [COORD_W-1:0] s_vertex_x;
    logic signed [COORD_W-1:0] s_vertex_y;
    logic [POS_W-1:0] s_position;
    logic m_valid;
    logic m_ready;
    logic signed [COORD_W-1:0] m_point_x;
    logic signed [COORD_W-1:0] m_point_y;
    logic [LEN_W-1:0] m_total_length;
    logic [1:0] m_status;

    polyline_arc_length_sampler i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_closed_path(cfg_closed_path),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_start_new(s_start_new), .s_vertex_x(s_vertex_x), .s_vertex_y(s_vertex_y),
        .s_position(s_position),
        .m_valid(m_valid), .m_ready(m_ready), .m_point_x(m_point_x),
        .m_point_y(m_point_y), .m_total_length(m_total_length), .m_status(m_status)
    );

    // path model
    logic                      closed_q;
    logic signed [COORD_W-1:0] path_x [MAX_POINTS];
    logic signed [COORD_W-1:0] path_y [MAX_POINTS];
    logic [LEN_W-1:0]          path_cum [MAX_POINTS];
    int unsigned               path_cnt;
    logic [LEN_W-1:0]          close_len;

    sample_t expected_q[$];
    int      fail_cnt;
    int      burst_left;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("polyline_arc_length_sampler: mismatch");
        $finish;
    end

    function automatic logic [63:0] sqrt_round(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] n;
        r = 0;
        b = 64'd1 << 62;
        n = v;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (n > r) r++;
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] segment_length(int a, int b);
        longint dx;
        longint dy;
        dx = longint'(path_x[a]) - longint'(path_x[b]);
        dy = longint'(path_y[a]) - longint'(path_y[b]);
        return LEN_W'(sqrt_round(64'(dx * dx) + 64'(dy * dy)));
    endfunction

    function automatic logic [LEN_W-1:0] add_sat(logic [LEN_W-1:0] a, logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_W] ? '1 : s[LEN_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] path_total();
        if (path_cnt == 0) return '0;
        return closed_q ? add_sat(path_cum[path_cnt-1], close_len) : path_cum[path_cnt-1];
    endfunction

    function automatic logic signed [COORD_W-1:0] blend(longint a, longint b, longint f);
        longint t;
        longint u;
        t = (b - a) * f;
        u = (t + (longint'(1) << 45) + 32768) >>> 16;
        return COORD_W'(a + (u - (longint'(1) << 29)));
    endfunction

    function automatic int slot(int i);
        return i >= int'(path_cnt) ? 0 : i;
    endfunction

    function automatic logic [LEN_W-1:0] slot_dist(int i, logic [LEN_W-1:0] tot);
        return i >= int'(path_cnt) ? tot : path_cum[i];
    endfunction

    function automatic sample_t sample_path(logic cmd, logic clr, logic signed [COORD_W-1:0] vx,
                                            logic signed [COORD_W-1:0] vy, logic [POS_W-1:0] pos);
        sample_t r;
        logic [LEN_W-1:0] tot;
        logic [63:0] p;
        logic [63:0] tgt;
        logic [63:0] d;
        logic [63:0] seg;
        logic [63:0] f;
        int lo;
        int hi;
        int mid;
        bit hit;
        r = '0;
        if (cmd == CMD_APPEND) begin
            if (clr) begin
                path_cnt = 0;
                close_len = '0;
            end
            if (path_cnt >= MAX_POINTS) begin
                r.st = ST_FULL;
            end else begin
                path_x[path_cnt] = vx;
                path_y[path_cnt] = vy;
                if (path_cnt == 0) begin
                    path_cum[0] = '0;
                    close_len = '0;
                end else begin
                    path_cum[path_cnt] = add_sat(path_cum[path_cnt-1],
                                                 segment_length(path_cnt - 1, path_cnt));
                    close_len = segment_length(path_cnt, 0);
                end
                path_cnt++;
                r.st = ST_OK;
            end
            r.len = path_total();
            return r;
        end
        if (path_cnt == 0) begin
            r.st = ST_EMPTY;
            return r;
        end
        tot = path_total();
        p = (pos > POS_ONE) ? 64'(POS_ONE) : 64'(pos);
        tgt = p * 64'(tot);
        lo = 0;
        hi = int'(path_cnt) + (closed_q ? 1 : 0) - 1;
        hit = 0;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            d = 64'(slot_dist(mid, tot)) << 16;
            if (d > tgt) begin
                hi = mid;
            end else if (d < tgt) begin
                lo = mid;
            end else begin
                r.x = path_x[slot(mid)];
                r.y = path_y[slot(mid)];
                hit = 1;
                break;
            end
        end
        if (!hit) begin
            seg = slot_dist(hi, tot) > slot_dist(lo, tot) ?
                  64'(slot_dist(hi, tot) - slot_dist(lo, tot)) : 64'd0;
            d = 64'(slot_dist(lo, tot)) << 16;
            f = 0;
            if (seg != 0 && tgt > d) begin
                f = ((tgt - d) + seg / 2) / seg;
                if (f > 65536) f = 65536;
            end
            r.x = blend(path_x[slot(lo)], path_x[slot(hi)], longint'(f));
            r.y = blend(path_y[slot(lo)], path_y[slot(hi)], longint'(f));
        end
        r.len = tot;
        r.st = ST_OK;
        return r;
    endfunction

    // result checker with its own stall pattern
    always @(posedge aclk) begin
        sample_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 7) != 0) || ($time / 20000 % 3 == 0);
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected transaction");
                    fail_cnt++;
                end else begin
                    e = expected_q.pop_front();
                    if (m_point_x !== e.x) begin
                        $error("point_x expected %0h actual %0h", e.x, m_point_x);
                        fail_cnt++;
                    end
                    if (m_point_y !== e.y) begin
                        $error("point_y expected %0h actual %0h", e.y, m_point_y);
                        fail_cnt++;
                    end
                    if (m_total_length !== e.len) begin
                        $error("total_length expected %0h actual %0h", e.len, m_total_length);
                        fail_cnt++;
                    end
                    if (m_status !== e.st) begin
                        $error("status expected %0h actual %0h", e.st, m_status);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    task automatic send_item(logic cmd, logic clr, logic signed [COORD_W-1:0] vx,
                             logic signed [COORD_W-1:0] vy, logic [POS_W-1:0] pos);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_command <= cmd;
        s_start_new <= clr;
        s_vertex_x <= vx;
        s_vertex_y <= vy;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
        expected_q.insert(expected_q.size(), sample_path(cmd, clr, vx, vy, pos));
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_closed(logic v);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_closed_path <= v;
        do @(posedge aclk); while (!cfg_ready);
        closed_q = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
        case (mode)
            0: return COORD_W'($urandom);
            1: return COORD_W'($signed($urandom_range(0, 4096)) - 2048);
            default: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return POS_ONE;
            2: return POS_W'($urandom);
            default: return POS_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic test_directed();
        send_item(CMD_QUERY, 1'b0, '0, '0, POS_ONE);
        send_item(CMD_APPEND, 1'b1, 24'sh7fffff, 24'sh800000, '0);
        send_item(CMD_QUERY, 1'b1, '0, '0, 17'h8000);
        send_item(CMD_APPEND, 1'b0, 24'sh800000, 24'sh7fffff, '0);
        send_item(CMD_APPEND, 1'b0, 24'sh800000, 24'sh7fffff, '0);
        send_item(CMD_QUERY, 1'b0, '0, '0, '0);
        send_item(CMD_QUERY, 1'b0, '0, '0, 17'h8000);
        send_item(CMD_QUERY, 1'b0, '0, '0, 17'h1ffff);
        send_item(CMD_APPEND, 1'b1, '0, '0, '0);
        send_item(CMD_APPEND, 1'b0, 24'sh000100, '0, '0);
        send_item(CMD_APPEND, 1'b0, 24'sh000200, '0, '0);
        send_item(CMD_APPEND, 1'b0, 24'sh000300, '0, '0);
        send_item(CMD_QUERY, 1'b0, '0, '0, 17'h5555);
        send_item(CMD_QUERY, 1'b0, '0, '0, 17'h8000);
        write_closed(1'b1);
        send_item(CMD_QUERY, 1'b0, '0, '0, 17'h8000);
        send_item(CMD_QUERY, 1'b0, '0, '0, 17'h1ffff);
        send_item(CMD_QUERY, 1'b0, '0, '0, 17'h7000);
        write_closed(1'b0);
    endtask

    task automatic test_full_store();
        send_item(CMD_APPEND, 1'b1, rand_coord(1), rand_coord(1), '0);
        for (int i = 0; i < MAX_POINTS + 2; i++)
            send_item(CMD_APPEND, 1'b0, rand_coord(1), rand_coord(1), '0);
        for (int i = 0; i < 20; i++) send_item(CMD_QUERY, 1'($urandom), '0, '0, rand_pos());
        write_closed(1'b1);
        for (int i = 0; i < 20; i++) send_item(CMD_QUERY, 1'($urandom), '0, '0, rand_pos());
    endtask

    task automatic test_random();
        int n;
        int mode;
        for (int p = 0; p < 40; p++) begin
            if (p % 8 == 0) write_closed(1'($urandom_range(0, 1)));
            n = $urandom_range(1, 12);
            mode = $urandom_range(0, 2);
            send_item(CMD_APPEND, 1'b1, rand_coord(mode), rand_coord(mode), POS_W'($urandom));
            for (int i = 1; i < n; i++)
                send_item(CMD_APPEND, $urandom_range(0, 15) == 0, rand_coord(mode),
                          rand_coord(mode), POS_W'($urandom));
            for (int i = 0; i < 20; i++)
                send_item(CMD_QUERY, 1'($urandom), rand_coord(0), rand_coord(0), rand_pos());
            if (p == 20) wait_drain();
        end
    endtask

    initial begin
        fail_cnt = 0;
        burst_left = 0;
        closed_q = 1'b0;
        path_cnt = 0;
        close_len = '0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_closed_path = 1'b0;
        s_valid = 1'b0;
        s_command = CMD_APPEND;
        s_start_new = 1'b0;
        s_vertex_x = '0;
        s_vertex_y = '0;
        s_position = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_store();
        test_random();
        wait_drain();
        if (fail_cnt == 0) begin
            $display("polyline_arc_length_sampler: match");
        end else begin
            $display("polyline_arc_length_sampler: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/pas_pkg.sv
rtl/core/pas_ctrl.sv
rtl/core/pas_dp.sv
rtl/core/polyline_arc_length_sampler.sv
verif/polyline_arc_length_sampler_tb.sv
